FILE: sv/pfa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfa_pkg: shared types and constants of the page frame allocator
// Command codes, field widths, controller states and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package pfa_pkg;

  // Field widths fixed by the interface
  localparam int CMD_W     = 1;
  localparam int PID_W     = 8;
  localparam int SIZE_W    = 18;
  localparam int PSZ_W     = 13;
  localparam int CNT_OUT_W = 7;

  // Dividend of the page count: size plus page size minus one
  localparam int NUM_W      = SIZE_W + 1;
  localparam int DIV_STEPS  = NUM_W;
  localparam int DIV_CNT_W  = 5;

  localparam logic [PSZ_W-1:0] PAGE_SIZE_RESET = 13'd4096;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_ALLOC   = 1'b0;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 1'b1;

  // Result status codes
  localparam logic STATUS_DONE    = 1'b0;
  localparam logic STATUS_REFUSED = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_CHECK,
    ST_ALLOC,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic clear;     // one step of the clearing pass
    logic load;      // capture the accepted item
    logic div_step;  // one quotient bit
    logic check;     // compare pages with free frames
    logic issue;     // issue one table read
    logic finish;    // settle the stack pointer
    logic emit;      // load the result register
  } pfa_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_last;
    logic div_last;
    logic fits;
    logic zero_pages;
    logic issue_last;
    logic out_free;
  } pfa_stat_t;

endpackage
`default_nettype wire

FILE: sv/pfa_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfa_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module pfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: sv/pfa_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfa_datapath: frame table, free stack, page count divider and result
// Holds the page size register, the stack pointer, the scan counter with
// its registered read stage, the restoring divider and the result register.
// ----------------------------------------------------------------------------
module pfa_datapath #(
  parameter int NUM_FRAMES = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [pfa_pkg::PSZ_W-1:0]     cfg_data,
  input  wire logic [pfa_pkg::CMD_W-1:0]     cmd_in,
  input  wire logic [pfa_pkg::PID_W-1:0]     pid_in,
  input  wire logic [pfa_pkg::SIZE_W-1:0]    size_in,
  input  wire pfa_pkg::pfa_cmd_t             ctl,
  output pfa_pkg::pfa_stat_t                 stat,
  input  wire logic                          out_ready,
  output logic                               out_valid,
  output logic                               status,
  output logic [pfa_pkg::CNT_OUT_W-1:0]      frame_count,
  output logic [pfa_pkg::CNT_OUT_W-1:0]      free_frames
);

  localparam int FW    = $clog2(NUM_FRAMES);
  localparam int CW    = $clog2(NUM_FRAMES + 1);
  localparam int OW    = 1 + pfa_pkg::PID_W + FW;
  localparam int QW    = pfa_pkg::NUM_W;
  localparam int OUT_W = pfa_pkg::CNT_OUT_W;

  localparam logic [FW-1:0] IDX_LAST = FW'(NUM_FRAMES - 1);
  localparam logic [CW-1:0] N_FRAMES = CW'(NUM_FRAMES);

  // Registers
  logic [pfa_pkg::PSZ_W-1:0] page_size;
  logic [pfa_pkg::CMD_W-1:0] cmd_r;
  logic [pfa_pkg::PID_W-1:0] pid_r;
  logic [FW-1:0]             idx;
  logic                      pend;
  logic [FW-1:0]             pend_addr;
  logic [CW-1:0]             sp;
  logic [CW-1:0]             count;
  logic                      refused;
  logic [QW-1:0]             dividend;
  logic [QW-1:0]             quo;
  logic [pfa_pkg::PSZ_W-1:0] rem;
  logic [pfa_pkg::DIV_CNT_W-1:0] div_cnt;

  // Combinational signals
  logic [pfa_pkg::PSZ_W-1:0] ps_eff;
  logic [QW-1:0]             num_init;
  logic [pfa_pkg::PSZ_W:0]   trial;
  logic                      trial_ge;
  logic [CW-1:0]             idx_c;
  logic [CW-1:0]             avail;
  logic                      fits;
  logic [CW-1:0]             sp_dec;
  logic [CW-1:0]             stk_sum;
  logic [FW-1:0]             stk_rdata;
  logic [OW-1:0]             own_rdata;
  logic                      own_valid;
  logic [pfa_pkg::PID_W-1:0] own_id;
  logic                      alloc_wr;
  logic                      rel_match;
  logic                      rel_push;
  logic                      stk_we;
  logic [FW-1:0]             stk_waddr;
  logic [FW-1:0]             stk_wdata;
  logic                      own_we;
  logic [FW-1:0]             own_waddr;
  logic [OW-1:0]             own_wdata;
  logic [CW+FW-1:0]          idx_wide;
  logic [OUT_W+CW-1:0]       cnt_wide;
  logic [OUT_W+CW-1:0]       free_wide;
  logic [QW+CW-1:0]          pages_cmp;
  logic [QW+CW-1:0]          avail_cmp;

  // Page size zero acts as one
  assign ps_eff   = (page_size == '0) ? {{(pfa_pkg::PSZ_W-1){1'b0}}, 1'b1} : page_size;
  assign num_init = {1'b0, size_in} + {{(QW-pfa_pkg::PSZ_W){1'b0}}, ps_eff} - {{(QW-1){1'b0}}, 1'b1};

  // One restoring division step
  assign trial    = {rem, dividend[QW-1]};
  assign trial_ge = (trial >= {1'b0, ps_eff});

  // Widen the scan index to count width
  assign idx_wide = {{CW{1'b0}}, idx};
  assign idx_c    = idx_wide[CW-1:0];

  // Free frames and the fit test
  assign avail     = N_FRAMES - sp;
  assign pages_cmp = {{CW{1'b0}}, quo};
  assign avail_cmp = {{QW{1'b0}}, avail};
  assign fits      = (pages_cmp <= avail_cmp);

  assign sp_dec  = sp - {{(CW-1){1'b0}}, 1'b1};
  assign stk_sum = sp + idx_c;

  // Owner entry layout: valid, process id, page number
  assign own_valid = own_rdata[OW-1];
  assign own_id    = own_rdata[OW-2 -: pfa_pkg::PID_W];

  // Read stage outcome
  assign alloc_wr  = pend && (cmd_r == pfa_pkg::CMD_ALLOC);
  assign rel_match = pend && (cmd_r == pfa_pkg::CMD_RELEASE) && own_valid && (own_id == pid_r);
  assign rel_push  = rel_match && (sp != '0);

  // Free stack write port
  assign stk_we    = ctl.clear || rel_push;
  assign stk_waddr = ctl.clear ? idx : sp_dec[FW-1:0];
  assign stk_wdata = ctl.clear ? idx : pend_addr;

  // Frame table write port
  always_comb begin
    own_we    = ctl.clear || alloc_wr || rel_match;
    own_waddr = pend_addr;
    own_wdata = {1'b0, pid_r, pend_addr};
    if (ctl.clear) begin
      own_waddr = idx;
      own_wdata = '0;
    end else if (alloc_wr) begin
      own_waddr = stk_rdata;
      own_wdata = {1'b1, pid_r, pend_addr};
    end
  end

  pfa_ram #(
    .WIDTH (FW),
    .DEPTH (NUM_FRAMES)
  ) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_sum[FW-1:0]),
    .rdata (stk_rdata)
  );

  pfa_ram #(
    .WIDTH (OW),
    .DEPTH (NUM_FRAMES)
  ) u_owner_ram (
    .clk   (clk),
    .we    (own_we),
    .waddr (own_waddr),
    .wdata (own_wdata),
    .raddr (idx),
    .rdata (own_rdata)
  );

  // Status towards the controller
  always_comb begin
    stat.clear_last = (idx == IDX_LAST);
    stat.div_last   = (div_cnt == pfa_pkg::DIV_CNT_W'(pfa_pkg::DIV_STEPS - 1));
    stat.fits       = fits;
    stat.zero_pages = (quo == '0);
    if (cmd_r == pfa_pkg::CMD_RELEASE) begin
      stat.issue_last = (idx == IDX_LAST);
    end else begin
      stat.issue_last = (idx_c == (count - {{(CW-1){1'b0}}, 1'b1}));
    end
    stat.out_free = !out_valid || out_ready;
  end

  assign cnt_wide  = {{OUT_W{1'b0}}, count};
  assign free_wide = {{OUT_W{1'b0}}, avail};

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      page_size <= pfa_pkg::PAGE_SIZE_RESET;
    end else if (cfg_we) begin
      page_size <= cfg_data;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      pend      <= 1'b0;
      sp        <= '0;
      out_valid <= 1'b0;
    end else begin
      pend <= ctl.issue;
      // advance the scan index
      if (ctl.clear) begin
        idx <= (idx == IDX_LAST) ? '0 : idx + {{(FW-1){1'b0}}, 1'b1};
      end else if (ctl.load) begin
        idx <= '0;
      end else if (ctl.issue) begin
        idx <= idx + {{(FW-1){1'b0}}, 1'b1};
      end
      // pop a whole allocation at once, push released frames one by one
      if (rel_push) begin
        sp <= sp_dec;
      end else if (ctl.finish && (cmd_r == pfa_pkg::CMD_ALLOC)) begin
        sp <= sp + count;
      end
      // hold the result until taken
      if (ctl.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (ctl.issue) begin
      pend_addr <= idx;
    end
    if (ctl.load) begin
      cmd_r    <= cmd_in;
      pid_r    <= pid_in;
      count    <= '0;
      refused  <= pfa_pkg::STATUS_DONE;
      dividend <= num_init;
      quo      <= '0;
      rem      <= '0;
      div_cnt  <= '0;
    end else begin
      if (ctl.div_step) begin
        dividend <= {dividend[QW-2:0], 1'b0};
        quo      <= {quo[QW-2:0], trial_ge};
        rem      <= trial_ge ? pfa_pkg::PSZ_W'(trial - {1'b0, ps_eff})
                             : trial[pfa_pkg::PSZ_W-1:0];
        div_cnt  <= div_cnt + {{(pfa_pkg::DIV_CNT_W-1){1'b0}}, 1'b1};
      end
      if (ctl.check) begin
        refused <= fits ? pfa_pkg::STATUS_DONE : pfa_pkg::STATUS_REFUSED;
        count   <= fits ? quo[CW-1:0] : '0;
      end else if (rel_match) begin
        count <= count + {{(CW-1){1'b0}}, 1'b1};
      end
    end
    if (ctl.emit) begin
      status      <= refused;
      frame_count <= cnt_wide[OUT_W-1:0];
      free_frames <= free_wide[OUT_W-1:0];
    end
  end

  // Assertions
  a_sp_bound : assert property (@(posedge clk) disable iff (rst)
    sp <= CW'(NUM_FRAMES))
    else $error("stack pointer beyond frame count");

  a_push_guard : assert property (@(posedge clk) disable iff (rst)
    rel_match |-> (sp != '0))
    else $error("released frame with empty allocation count");

  a_refuse_zero : assert property (@(posedge clk) disable iff (rst)
    (ctl.emit && (refused == pfa_pkg::STATUS_REFUSED)) |-> (count == '0))
    else $error("refused allocation reports frames");

  a_clear_quiet : assert property (@(posedge clk) disable iff (rst)
    ctl.clear |-> (!out_valid && !pend))
    else $error("activity during clearing pass");

endmodule
`default_nettype wire

FILE: sv/pfa_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfa_ctrl: allocator sequencer
// Runs the clearing pass, then per item the divide and fit check (allocations
// only), the table pass unless refused or empty, and the result hand-over.
// ----------------------------------------------------------------------------
module pfa_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  input  wire logic [pfa_pkg::CMD_W-1:0] cmd_in,
  output logic                           in_ready,
  input  wire pfa_pkg::pfa_stat_t        stat,
  output pfa_pkg::pfa_cmd_t              ctl
);

  pfa_pkg::state_t state;
  pfa_pkg::state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pfa_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      pfa_pkg::ST_CLEAR: begin
        if (stat.clear_last) state_next = pfa_pkg::ST_IDLE;
      end
      pfa_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = (cmd_in == pfa_pkg::CMD_RELEASE) ? pfa_pkg::ST_SCAN : pfa_pkg::ST_DIV;
        end
      end
      pfa_pkg::ST_DIV: begin
        if (stat.div_last) state_next = pfa_pkg::ST_CHECK;
      end
      pfa_pkg::ST_CHECK: begin
        state_next = (stat.fits && !stat.zero_pages) ? pfa_pkg::ST_ALLOC : pfa_pkg::ST_DONE;
      end
      pfa_pkg::ST_ALLOC: begin
        if (stat.issue_last) state_next = pfa_pkg::ST_DRAIN;
      end
      pfa_pkg::ST_SCAN: begin
        if (stat.issue_last) state_next = pfa_pkg::ST_DRAIN;
      end
      pfa_pkg::ST_DRAIN: begin
        state_next = pfa_pkg::ST_DONE;
      end
      pfa_pkg::ST_DONE: begin
        if (stat.out_free) state_next = pfa_pkg::ST_IDLE;
      end
      default: begin
        state_next = pfa_pkg::ST_CLEAR;
      end
    endcase
  end

  // Outputs
  always_comb begin
    ctl      = '0;
    in_ready = 1'b0;
    case (state)
      pfa_pkg::ST_CLEAR: ctl.clear = 1'b1;
      pfa_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        ctl.load = in_valid;
      end
      pfa_pkg::ST_DIV:   ctl.div_step = 1'b1;
      pfa_pkg::ST_CHECK: ctl.check = 1'b1;
      pfa_pkg::ST_ALLOC: ctl.issue = 1'b1;
      pfa_pkg::ST_SCAN:  ctl.issue = 1'b1;
      pfa_pkg::ST_DRAIN: ctl.finish = 1'b1;
      pfa_pkg::ST_DONE:  ctl.emit = stat.out_free;
      default: begin
        ctl = '0;
      end
    endcase
  end

  // Assertions
  a_div_then_check : assert property (@(posedge clk) disable iff (rst)
    (state == pfa_pkg::ST_CHECK) |-> ($past(state) == pfa_pkg::ST_DIV))
    else $error("fit check without a finished divide");

  a_drain_once : assert property (@(posedge clk) disable iff (rst)
    (state == pfa_pkg::ST_DRAIN) |=> (state == pfa_pkg::ST_DONE))
    else $error("drain not followed by result");

  a_load_idle : assert property (@(posedge clk) disable iff (rst)
    ctl.load |=> (state != pfa_pkg::ST_IDLE))
    else $error("accepted item left without work");

endmodule
`default_nettype wire

FILE: sv/page_frame_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// page_frame_allocator: physical frame allocator with free stack
// Allocates frames to processes from a free-frame stack and releases all
// frames of a process by a scan of the frame table.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass that fills the free stack with
// frames in order and marks every frame unowned; in_ready stays low
// meanwhile, while page size writes are taken at any time. Items are handled
// one at a time. An allocation first forms its page count in the bit-serial
// page count divider; unless it is refused or needs no frame, the frames are
// then taken at one per cycle through the single write port of the frame
// table. A release scans the whole frame table, reading one table entry per
// cycle. Each item gives exactly one result, held in an output register
// until taken.
// ----------------------------------------------------------------------------
module page_frame_allocator #(
  parameter int NUM_FRAMES = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [pfa_pkg::PSZ_W-1:0]     cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [pfa_pkg::CMD_W-1:0]     cmd,
  input  wire logic [pfa_pkg::PID_W-1:0]     process_id,
  input  wire logic [pfa_pkg::SIZE_W-1:0]    size_bytes,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               status,
  output logic [pfa_pkg::CNT_OUT_W-1:0]      frame_count,
  output logic [pfa_pkg::CNT_OUT_W-1:0]      free_frames
);

  pfa_pkg::pfa_cmd_t  ctl;
  pfa_pkg::pfa_stat_t stat;

  // Page size writes are always taken
  assign cfg_ready = 1'b1;

  pfa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .cmd_in   (cmd),
    .in_ready (in_ready),
    .stat     (stat),
    .ctl      (ctl)
  );

  pfa_datapath #(
    .NUM_FRAMES (NUM_FRAMES)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_data    (cfg_data),
    .cmd_in      (cmd),
    .pid_in      (process_id),
    .size_in     (size_bytes),
    .ctl         (ctl),
    .stat        (stat),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .status      (status),
    .frame_count (frame_count),
    .free_frames (free_frames)
  );

endmodule
`default_nettype wire
